@@ src/lts_pkg.sv @@
// ----------------------------------------------------------------------------
// lts_pkg: shared types and constants of the lottery ticket scheduler.
// Holds the beat payload structs, the controller state and scan mode enums,
// the command and status bundles between controller and datapath, and the
// generator constants.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int INDEX_W        = 6;
    localparam int TICKET_W       = 16;
    localparam int ARRIVAL_W      = 32;

    // Linear congruential generator, modulo 2^32.
    localparam logic [31:0] LCG_MUL   = 32'd1103515245;
    localparam logic [31:0] LCG_ADD   = 32'd12345;
    localparam logic [31:0] LCG_SEED  = 32'd1;
    // The drawn value is bits 16..30 of the generator state.
    localparam int          DRAW_LSB  = 16;
    localparam int          DRAW_W    = 15;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_PICK   = 1'b1;

    typedef struct packed {
        logic                 opcode;
        logic [INDEX_W-1:0]   slot_index;
        logic                 slot_runnable;
        logic [TICKET_W-1:0]  slot_tickets;
        logic [ARRIVAL_W-1:0] slot_arrival;
    } lts_req_t;

    typedef struct packed {
        logic               winner_found;
        logic [INDEX_W-1:0] winner_index;
    } lts_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DRAW,
        ST_DIV,
        ST_WALK,
        ST_REPL,
        ST_DONE
    } lts_state_t;

    typedef enum logic [1:0] {
        MODE_SUM,
        MODE_WALK,
        MODE_REPL
    } lts_mode_t;

    typedef struct packed {
        logic      write_slot;
        logic      scan_start;
        logic      scan_run;
        lts_mode_t mode;
        logic      lcg_step;
        logic      div_start;
        logic      div_run;
        logic      finish;
    } lts_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic total_zero;
        logic div_done;
        logic rsp_free;
    } lts_sts_t;

endpackage

@@ src/lottery_ticket_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// lottery_ticket_scheduler_core: lottery scheduler over a table of task slots.
// An update beat writes one slot; a pick beat draws a lottery winner among
// the runnable slots, breaks ticket ties by earliest arrival, reports the
// winner and clears its runnable flag.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                    Direction  Beat content
//  -------  -------------------------  ---------  ----------------------------
//  req      req_valid/req_ready/req    in         opcode and slot fields
//  rsp      rsp_valid/rsp_ready/rsp    out        winner_found, winner_index
//
// An update beat is accepted while idle and gives no response. A pick
// runs three full scans of the slot memory at one read port entry per
// cycle, with a bit-serial modulo over the 15-bit draw after the first;
// a pick that finds no tickets ends after the first scan.
// Reset clears all runnable flags and seeds the generator; no clearing pass
// is needed because stored tickets and arrivals are only used for runnable
// slots. A stalled response sits in the output register while the next beat
// is accepted; a second pick then waits at its end until the register frees.
//
// The controller sequences the pick; the datapath holds the slot memory,
// the generator, the modulo unit and the scan registers.

module lottery_ticket_scheduler_core
    import lts_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  lts_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output lts_rsp_t rsp
);

    lts_cmd_t cmd;
    lts_sts_t sts;

    // The sequencer decides when a beat is accepted and walks the phases.
    lts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_opcode (req.opcode),
        .req_ready  (req_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // The datapath owns all state but the sequencer's phase, including the response register.
    lts_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

@@ src/lts_ctrl.sv @@
// ----------------------------------------------------------------------------
// lts_ctrl: sequencer of the lottery ticket scheduler.
// Steps a pick through the ticket sum, the draw, the modulo, the lottery
// walk and the arrival tie-break scan, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module lts_ctrl
    import lts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_opcode,
    output logic     req_ready,
    input  lts_sts_t sts,
    output lts_cmd_t cmd
);

    lts_state_t state_reg;
    lts_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && (req_opcode == OP_PICK))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.total_zero ? ST_DONE : ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_REPL;
                end
            end
            ST_REPL:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        cmd.mode  = MODE_SUM;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready      = 1'b1;
                cmd.write_slot = req_valid && (req_opcode == OP_UPDATE);
                cmd.scan_start = req_valid && (req_opcode == OP_PICK);
                cmd.mode       = MODE_SUM;
            end
            ST_SUM:
            begin
                cmd.scan_run = 1'b1;
                cmd.mode     = MODE_SUM;
            end
            ST_DRAW:
            begin
                cmd.lcg_step  = 1'b1;
                cmd.div_start = 1'b1;
            end
            ST_DIV:
            begin
                cmd.mode = MODE_WALK;
                if (sts.div_done)
                begin
                    cmd.scan_start = 1'b1;
                end
                else
                begin
                    cmd.div_run = 1'b1;
                end
            end
            ST_WALK:
            begin
                cmd.scan_run = 1'b1;
                cmd.mode     = MODE_WALK;
                if (sts.scan_done)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.mode       = MODE_REPL;
                end
            end
            ST_REPL:
            begin
                cmd.scan_run = 1'b1;
                cmd.mode     = MODE_REPL;
            end
            ST_DONE:
            begin
                cmd.finish = sts.rsp_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ src/lts_datapath.sv @@
// ----------------------------------------------------------------------------
// lts_datapath: slot table, generator, modulo unit and scan datapath.
// Slot tickets and arrivals live in a one-write, one-read memory; runnable
// flags are flip-flops cleared by reset. A scan reads one slot per cycle.
// ----------------------------------------------------------------------------
module lts_datapath
    import lts_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  lts_req_t req,
    input  lts_cmd_t cmd,
    output lts_sts_t sts,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output lts_rsp_t rsp
);

    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int CNT_W   = IDX_W + 1;
    localparam int SUM_W   = TICKET_W + IDX_W;
    localparam int ENTRY_W = TICKET_W + ARRIVAL_W;
    localparam int EXT_W   = IDX_W + INDEX_W;
    localparam int DIVC_W  = $clog2(DRAW_W + 1);

    logic [ENTRY_W-1:0]    slot_mem [SLOT_COUNT];
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic [SLOT_COUNT-1:0] run_reg, run_next;

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  tag_vld_reg, tag_vld_next;
    logic [IDX_W-1:0]      tag_idx_reg;
    logic                  tag_run_reg;

    logic [31:0]           lcg_reg, lcg_next;
    logic [SUM_W-1:0]      total_reg, total_next;
    logic [DRAW_W-1:0]     rem_reg, rem_next;
    logic [DIVC_W-1:0]     div_cnt_reg, div_cnt_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      win_reg, win_next;
    logic [TICKET_W-1:0]   wt_reg, wt_next;
    logic [ARRIVAL_W-1:0]  win_arr_reg, win_arr_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    lts_rsp_t              rsp_reg, rsp_next;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [EXT_W-1:0]      wr_ext;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [TICKET_W-1:0]   rd_tickets;
    logic [ARRIVAL_W-1:0]  rd_arrival;
    logic                  proc;
    logic [DRAW_W-1:0]     draw;
    logic [DIVC_W-1:0]     bit_sel;
    logic [DRAW_W:0]       rem_sh;
    logic [SUM_W-1:0]      rem_ext;
    logic [TICKET_W-1:0]   ticket_ext;
    logic                  nonzero;
    logic [EXT_W-1:0]      win_ext;

    assign rd_en   = cmd.scan_run && (cnt_reg < CNT_W'(SLOT_COUNT));
    assign rd_addr = cnt_reg[IDX_W-1:0];

    // Update beats beyond the table are dropped.
    assign wr_ext  = {{IDX_W{1'b0}}, req.slot_index};
    assign wr_en   = cmd.write_slot && (wr_ext < EXT_W'(SLOT_COUNT));
    assign wr_addr = wr_ext[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= {req.slot_tickets, req.slot_arrival};
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_tickets = rd_data_reg[ENTRY_W-1 -: TICKET_W];
    assign rd_arrival = rd_data_reg[ARRIVAL_W-1:0];
    assign proc       = tag_vld_reg && tag_run_reg;

    assign draw       = lcg_reg[DRAW_LSB +: DRAW_W];
    assign bit_sel    = div_cnt_reg - DIVC_W'(1);
    assign rem_sh     = {rem_reg, draw[bit_sel]};
    assign rem_ext    = SUM_W'(rem_sh);
    assign ticket_ext = TICKET_W'(rem_reg);
    assign nonzero    = (total_reg != '0);
    assign win_ext    = {{INDEX_W{1'b0}}, win_reg};

    always_comb
    begin
        cnt_next     = cnt_reg;
        tag_vld_next = 1'b0;
        run_next     = run_reg;
        lcg_next     = lcg_reg;
        total_next   = total_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        found_next   = found_reg;
        win_next     = win_reg;
        wt_next      = wt_reg;
        win_arr_next = win_arr_reg;

        if (cmd.scan_start)
        begin
            cnt_next = '0;
        end
        else if (rd_en)
        begin
            cnt_next     = cnt_reg + CNT_W'(1);
            tag_vld_next = 1'b1;
        end

        if (cmd.scan_start && (cmd.mode == MODE_SUM))
        begin
            total_next = '0;
        end
        else if (proc && (cmd.mode == MODE_SUM))
        begin
            total_next = total_reg + SUM_W'(rd_tickets);
        end

        if (cmd.lcg_step)
        begin
            lcg_next = 32'(lcg_reg * LCG_MUL + LCG_ADD);
        end

        // Restoring remainder, one dividend bit per cycle, MSB first.
        if (cmd.div_start)
        begin
            rem_next     = '0;
            div_cnt_next = DIVC_W'(DRAW_W);
        end
        else if (cmd.div_run)
        begin
            div_cnt_next = bit_sel;
            if (rem_ext >= total_reg)
            begin
                rem_next = DRAW_W'(rem_ext - total_reg);
            end
            else
            begin
                rem_next = rem_sh[DRAW_W-1:0];
            end
        end
        else if (cmd.scan_start && (cmd.mode == MODE_WALK))
        begin
            found_next = 1'b0;
            win_next   = '0;
        end
        else if (proc && (cmd.mode == MODE_WALK) && !found_reg)
        begin
            if (ticket_ext < rd_tickets)
            begin
                found_next   = 1'b1;
                win_next     = tag_idx_reg;
                wt_next      = rd_tickets;
                win_arr_next = rd_arrival;
            end
            else
            begin
                rem_next = DRAW_W'(ticket_ext - rd_tickets);
            end
        end
        else if (proc && (cmd.mode == MODE_REPL) && (rd_tickets == wt_reg) &&
                 (rd_arrival < win_arr_reg))
        begin
            win_next     = tag_idx_reg;
            win_arr_next = rd_arrival;
        end

        if (wr_en)
        begin
            run_next[wr_addr] = req.slot_runnable;
        end
        if (cmd.finish && nonzero)
        begin
            run_next[win_reg] = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (cmd.finish)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.winner_found = nonzero;
            rsp_next.winner_index = nonzero ? win_ext[INDEX_W-1:0] : '0;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            cnt_reg       <= '0;
            tag_vld_reg   <= 1'b0;
            lcg_reg       <= LCG_SEED;
            div_cnt_reg   <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            cnt_reg       <= cnt_next;
            tag_vld_reg   <= tag_vld_next;
            lcg_reg       <= lcg_next;
            div_cnt_reg   <= div_cnt_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_idx_reg <= rd_addr;
        tag_run_reg <= run_reg[rd_addr];
        total_reg   <= total_next;
        rem_reg     <= rem_next;
        win_reg     <= win_next;
        wt_reg      <= wt_next;
        win_arr_reg <= win_arr_next;
        rsp_reg     <= rsp_next;
    end

    assign sts.scan_done  = (cnt_reg == CNT_W'(SLOT_COUNT)) && !tag_vld_reg;
    assign sts.total_zero = !nonzero;
    assign sts.div_done   = (div_cnt_reg == '0);
    assign sts.rsp_free   = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ src/lts_checker.sv @@
// ----------------------------------------------------------------------------
// lts_checker: port-level checks of the lottery ticket scheduler.
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module lts_checker
    import lts_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input lts_req_t req,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input lts_rsp_t rsp
);

    // A response beat that is not taken holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // A response without a winner carries index zero.
    a_rsp_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.winner_found |-> rsp.winner_index == '0)
        else $error("empty response with nonzero index");

    // After a pick is accepted, the block takes no beat in the following cycle.
    a_pick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.opcode == OP_PICK) |=> !req_ready)
        else $error("beat accepted right after a pick");

    // An update never produces a response.
    a_update_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.opcode == OP_UPDATE) && !rsp_valid
        |=> !rsp_valid)
        else $error("response after an update");

endmodule

bind lottery_ticket_scheduler_core lts_checker u_lts_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for lottery_ticket_scheduler_core.
// A scoreboard keeps its own copy of the slot table and the generator and
// predicts every pick. It checks each response beat against the oldest
// prediction. The stimulus starts with a short directed run over the empty
// table, zero-ticket slots, extreme field values and arrival ties. It then
// sends random write-then-pick sequences under several idle and stall mixes,
// with one long response hold-off.
// ----------------------------------------------------------------------------

module tb_top;
    import lts_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int SLOTS        = SLOT_COUNT_DEF;

    // Roughly 2000 beats, all of them picks that meet heavy stalls, fit well
    // inside this bound.
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned HOLD_CYCLES  = 3000;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned MAX_REPORTS  = 10;

    // Generator constants, as the scheduler defines them.
    localparam bit [31:0] GEN_MUL  = 32'd1103515245;
    localparam bit [31:0] GEN_INC  = 32'd12345;
    localparam bit [31:0] GEN_SEED = 32'd1;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the slot table and the generator. Every accepted
    // pick queues the winner it should produce.
    // ------------------------------------------------------------------------
    class winner_scoreboard;
        bit                 runnable [SLOTS];
        bit [TICKET_W-1:0]  tickets  [SLOTS];
        bit [ARRIVAL_W-1:0] arrival  [SLOTS];
        bit [31:0]          lcg;
        lts_rsp_t           expected_winners [$];
        int unsigned        updates;
        int unsigned        picks;
        int unsigned        empty_picks;
        int unsigned        tie_moves;
        int unsigned        results;
        int unsigned        mismatches;

        function new();
            foreach (runnable[i])
            begin
                runnable[i] = 1'b0;
                tickets[i]  = '0;
                arrival[i]  = '0;
            end
            lcg         = GEN_SEED;
            updates     = 0;
            picks       = 0;
            empty_picks = 0;
            tie_moves   = 0;
            results     = 0;
            mismatches  = 0;
        endfunction

        // Runs one lottery over the table and clears the winner's flag.
        function lts_rsp_t draw_winner();
            int unsigned       total;
            int unsigned       ticket;
            int unsigned       win;
            int unsigned       drawn;
            bit                hit;
            bit [TICKET_W-1:0] win_tickets;
            lts_rsp_t          r;
            r     = '0;
            total = 0;
            for (int i = 0; i < SLOTS; i++)
                if (runnable[i])
                    total += tickets[i];
            if (total == 0)
            begin
                empty_picks++;
                return r;
            end
            // The drawn value is bits 16..30 of the advanced generator.
            lcg    = lcg * GEN_MUL + GEN_INC;
            ticket = 32'(lcg[30:16]) % total;
            win    = 0;
            hit    = 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (runnable[i] && !hit)
                begin
                    if (ticket < tickets[i])
                    begin
                        win = i;
                        hit = 1'b1;
                    end
                    else
                        ticket -= tickets[i];
                end
            end
            // Move to a strictly earlier arrival among equal ticket counts.
            drawn       = win;
            win_tickets = tickets[win];
            for (int i = 0; i < SLOTS; i++)
                if (runnable[i] && tickets[i] == win_tickets && arrival[i] < arrival[win])
                    win = i;
            if (win != drawn)
                tie_moves++;
            runnable[win]  = 1'b0;
            r.winner_found = 1'b1;
            r.winner_index = INDEX_W'(win);
            return r;
        endfunction

        function void note_request(lts_req_t beat);
            if (beat.opcode == OP_PICK)
            begin
                picks++;
                expected_winners.push_back(draw_winner());
            end
            else if (beat.slot_index < SLOTS)
            begin
                updates++;
                runnable[beat.slot_index] = beat.slot_runnable;
                tickets[beat.slot_index]  = beat.slot_tickets;
                arrival[beat.slot_index]  = beat.slot_arrival;
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] MISMATCH on response %0d: %s", $realtime, results, msg);
        endfunction

        function void check_winner(lts_rsp_t got);
            lts_rsp_t want;
            results++;
            if (expected_winners.size() == 0)
            begin
                flag($sformatf("response with no pick pending (found=%0b index=%0d)",
                               got.winner_found, got.winner_index));
                return;
            end
            want = expected_winners.pop_front();
            if (got.winner_found !== want.winner_found)
                flag($sformatf("winner_found expected %0b, got %0b",
                               want.winner_found, got.winner_found));
            if (got.winner_index !== want.winner_index)
                flag($sformatf("winner_index expected %0d, got %0d",
                               want.winner_index, got.winner_index));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input has a known value from
    // time zero on.
    // ------------------------------------------------------------------------
    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    lts_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    lts_rsp_t rsp;

    // Percentages of cycles in which the sender idles or the receiver stalls.
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;

    // The main sequence requests a hold-off by bumping holds_requested. The
    // receiver process loads its own cycle counter when it sees the request.
    int unsigned holds_requested = 0;
    int unsigned holds_served    = 0;
    int unsigned hold_left       = 0;

    int unsigned cycle_count = 0;

    winner_scoreboard board;

    always #(CLK_PERIOD / 2) clk = ~clk;

    lottery_ticket_scheduler_core #(
        .SLOT_COUNT (SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // The watchdog ends a run that hangs. A missing response then shows up
    // here and not as a silent pass.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[%0t] Timeout after %0d cycles, %0d picks still unanswered",
                     $realtime, cycle_count, board.expected_winners.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Both channels are sampled at the rising edge. The response check runs
    // first, so a pick accepted in the same cycle cannot match a result
    // that belongs to an earlier pick.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                board.check_winner(rsp);
            if (req_valid && req_ready)
                board.note_request(req);
        end
    end

    // The receiver drives ready at the falling edge. During a hold-off it
    // keeps ready low until its counter, loaded from HOLD_CYCLES, runs out. The block then fills up and
    // stops taking beats.
    always @(negedge clk)
    begin
        if (hold_left == 0 && holds_served != holds_requested)
        begin
            holds_served = holds_served + 1;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Beat builders.
    // ------------------------------------------------------------------------
    function automatic lts_req_t noise_beat();
        lts_req_t b;
        b.opcode        = 1'($urandom_range(1));
        b.slot_index    = INDEX_W'($urandom());
        b.slot_runnable = 1'($urandom_range(1));
        b.slot_tickets  = TICKET_W'($urandom());
        b.slot_arrival  = $urandom();
        return b;
    endfunction

    // A pick carries random slot fields, which the block must ignore.
    function automatic lts_req_t pick_beat();
        lts_req_t b;
        b        = noise_beat();
        b.opcode = OP_PICK;
        return b;
    endfunction

    function automatic lts_req_t slot_beat(int unsigned idx, bit run,
                                           bit [TICKET_W-1:0] tix,
                                           bit [ARRIVAL_W-1:0] arr);
        lts_req_t b;
        b.opcode        = OP_UPDATE;
        b.slot_index    = INDEX_W'(idx);
        b.slot_runnable = run;
        b.slot_tickets  = tix;
        b.slot_arrival  = arr;
        return b;
    endfunction

    // Small ticket counts dominate, so equal counts and arrival ties come up
    // often. Full-range values still reach every bit.
    function automatic bit [TICKET_W-1:0] random_tickets();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 55)
            return TICKET_W'($urandom_range(1, 4));
        if (roll < 85)
            return TICKET_W'($urandom_range(5, 600));
        return TICKET_W'($urandom());
    endfunction

    function automatic bit [ARRIVAL_W-1:0] random_arrival();
        if ($urandom_range(99) < 50)
            return ARRIVAL_W'($urandom_range(0, 7));
        return $urandom();
    endfunction

    function automatic lts_req_t random_slot_beat();
        return slot_beat($urandom_range(0, SLOTS - 1), $urandom_range(99) < 85,
                         random_tickets(), random_arrival());
    endfunction

    // ------------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------------

    // Offers one beat from the falling edge on and returns at the rising
    // edge that accepts it. Valid stays high into the next call, so
    // back-to-back beats leave no gap.
    task automatic send_beat(lts_req_t beat);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Takes valid down and waits until every predicted winner has come back.
    task automatic wait_for_winners();
        @(negedge clk);
        req_valid <= 1'b0;
        while (board.expected_winners.size() != 0)
            @(posedge clk);
    endtask

    // Most sequences are a batch of slot writes followed by a few picks,
    // which keeps the table populated and the lottery busy. About one sequence
    // in eight is a single fully random beat of either kind.
    task automatic run_sequences(int unsigned beat_count);
        int unsigned sent;
        int unsigned writes;
        int unsigned draws;
        sent = 0;
        while (sent < beat_count)
        begin
            if ($urandom_range(99) < 12)
            begin
                send_beat(noise_beat());
                sent++;
            end
            else
            begin
                writes = $urandom_range(1, 10);
                draws  = $urandom_range(1, 5);
                repeat (writes)
                    send_beat(random_slot_beat());
                repeat (draws)
                    send_beat(pick_beat());
                sent += writes + draws;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. A pick on the empty table, then slots that are
        // runnable but hold no tickets: both picks must report no winner.
        send_beat(pick_beat());
        send_beat(slot_beat(0, 1'b1, '0, '0));
        send_beat(slot_beat(SLOTS - 1, 1'b1, '0, '1));
        send_beat(pick_beat());
        // The top slot holds the maximum ticket count and arrival. It must
        // win and then drop out, which leaves the table empty again.
        send_beat(slot_beat(SLOTS - 1, 1'b1, '1, '1));
        send_beat(pick_beat());
        send_beat(pick_beat());
        // Three slots hold equal counts. Two of them share the earliest
        // arrival, so a drawn late slot moves to the lower index, while a
        // drawn early slot stays put. An idle slot with an earlier arrival
        // must not be chosen.
        send_beat(slot_beat(10, 1'b1, 16'd5, 32'd7));
        send_beat(slot_beat(20, 1'b1, 16'd5, 32'd7));
        send_beat(slot_beat(30, 1'b1, 16'd5, 32'd9));
        send_beat(slot_beat(40, 1'b0, 16'd5, 32'd0));
        send_beat(slot_beat(1, 1'b1, 16'd1, 32'h8000_0000));
        send_beat(slot_beat(45, 1'b1, 16'd2, 32'd3));
        // Drain all five runnable slots, then one pick on an empty table.
        repeat (6)
            send_beat(pick_beat());
        wait_for_winners();

        // Random part across the idle mixes.
        run_sequences(380);
        sender_idle_pct = 51;
        run_sequences(380);
        wait_for_winners();
        sender_idle_pct    = 0;
        receiver_stall_pct = 51;
        run_sequences(380);
        sender_idle_pct    = 13;
        receiver_stall_pct = 13;
        run_sequences(380);

        // Back pressure. Fill the table, then hold the response channel
        // while beats keep coming, so that the input stalls behind a
        // finished pick.
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (16)
            send_beat(random_slot_beat());
        holds_requested = holds_requested + 1;
        run_sequences(60);
        // The sender now pauses until the block has answered everything.
        wait_for_winners();

        run_sequences(400);
        wait_for_winners();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d slot writes and %0d picks: %0d found no tickets, %0d moved to an earlier arrival.",
                 board.updates, board.picks, board.empty_picks, board.tie_moves);
        $display("Swept idle and stall mixes with a %0d-cycle response hold-off; %0d responses, %0d mismatches.",
                 HOLD_CYCLES, board.results, board.mismatches);
        if (board.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
